// ===== rtl/core/pls_pkg.sv =====
// shared types and constants for the posting list splicer
`timescale 1ns / 1ps
package pls_pkg;

  typedef enum logic [1:0] {
    OP_TERM = 2'd0,
    OP_DOC  = 2'd1,
    OP_HIT  = 2'd2,
    OP_END  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_HIT     = 2'd1,
    KIND_TRAILER = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_HDR,
    ST_RDWAIT,
    ST_HITS,
    ST_TRAIL
  } state_t;

endpackage

// ===== rtl/core/posting_list_splicer_unit.sv =====
// top level of the posting list splicer: sequencer, insertion sort and output
`timescale 1ns / 1ps
//  channel | direction | ports
//  in_     | input     | in_valid, in_stall, in_opcode .. in_position
//  out_    | output    | out_valid, out_stall, out_kind .. out_last
// a term header or a document header with no flush is taken in ST_IDLE, which it does not leave
// a kept hit steps through ST_SHIFT, moving stored entries up until its place is found,
// one entry read, compared and shifted each cycle through the store port;
// a dropped hit or a hit into a full store is taken in ST_IDLE, which it does not leave
// a flush emits a header in ST_HDR, then per hit a read in ST_RDWAIT and an output in ST_HITS,
// then a trailer in ST_TRAIL at end of term
// rst_n is synchronous; the store needs no clearing, only held entries are read
// out_stall holds the current result; in_stall is high while an item is worked
module posting_list_splicer_unit #(
  parameter int unsigned MAX_HITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_term_id,
  input  logic [31:0] in_doc_id,
  input  logic [7:0]  in_language,
  input  logic [15:0] in_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [31:0] out_out_term,
  output logic [31:0] out_record_count,
  output logic [31:0] out_out_doc,
  output logic [7:0]  out_out_language,
  output logic [5:0]  out_hit_total,
  output logic [15:0] out_out_position,
  output logic        out_last
);
  import pls_pkg::*;

  localparam int unsigned IW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
  localparam int unsigned CW = $clog2(MAX_HITS + 1);

  state_t      state_r, state_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [15:0] prev_hit_r, prev_hit_nxt;
  logic [31:0] prev_doc_r, prev_doc_nxt;
  logic [7:0]  prev_lang_r, prev_lang_nxt;
  logic [31:0] term_r, term_nxt;
  logic [31:0] recs_r, recs_nxt;
  logic [15:0] newhit_r, newhit_nxt;
  logic [31:0] newdoc_r, newdoc_nxt;
  logic [7:0]  newlang_r, newlang_nxt;
  logic        trail_r, trail_nxt;

  logic        we;
  logic [IW-1:0] waddr, raddr;
  logic [15:0] wdata, rdata;

  logic        acc, emit;
  opcode_t     op;

  assign acc  = in_valid && !in_stall;
  assign emit = out_valid && !out_stall;
  assign op   = opcode_t'(in_opcode);

  pls_store #(.MAX_HITS(MAX_HITS), .IW(IW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      held_r     <= '0;
      prev_hit_r <= '0;
      prev_doc_r <= '0;
      prev_lang_r <= '0;
      term_r     <= '0;
      recs_r     <= '0;
      trail_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      held_r     <= held_nxt;
      prev_hit_r <= prev_hit_nxt;
      prev_doc_r <= prev_doc_nxt;
      prev_lang_r <= prev_lang_nxt;
      term_r     <= term_nxt;
      recs_r     <= recs_nxt;
      trail_r    <= trail_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    newhit_r  <= newhit_nxt;
    newdoc_r  <= newdoc_nxt;
    newlang_r <= newlang_nxt;
  end

  // next state and datapath updates
  always_comb begin
    state_nxt    = state_r;
    held_nxt     = held_r;
    idx_nxt      = idx_r;
    prev_hit_nxt = prev_hit_r;
    prev_doc_nxt = prev_doc_r;
    prev_lang_nxt = prev_lang_r;
    term_nxt     = term_r;
    recs_nxt     = recs_r;
    newhit_nxt   = newhit_r;
    newdoc_nxt   = newdoc_r;
    newlang_nxt  = newlang_r;
    trail_nxt    = trail_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (op)
            OP_TERM: begin
              term_nxt = in_term_id;
              held_nxt = '0;
              prev_hit_nxt = '0;
              prev_doc_nxt = '0;
              recs_nxt = '0;
            end
            OP_DOC: begin
              if (in_doc_id != prev_doc_r && prev_doc_r != '0) begin
                // old document goes out first, new one is loaded after the flush
                newdoc_nxt = in_doc_id;
                newlang_nxt = in_language;
                state_nxt = ST_HDR;
                trail_nxt = 1'b0;
              end else begin
                prev_doc_nxt = in_doc_id;
                prev_lang_nxt = in_language;
              end
            end
            OP_HIT: begin
              if (held_r < CW'(MAX_HITS)) begin
                prev_hit_nxt = in_position;
                if (in_position != prev_hit_r) begin
                  newhit_nxt = in_position;
                  idx_nxt = held_r;
                  state_nxt = ST_SHIFT;
                end
              end
            end
            default: begin
              state_nxt = ST_HDR;
              trail_nxt = 1'b1;
            end
          endcase
        end
      end
      // one step of insertion: rdata holds entry idx-1
      ST_SHIFT: begin
        if (idx_r != '0 && rdata > newhit_r) begin
          idx_nxt = idx_r - CW'(1);
        end else begin
          held_nxt = held_r + CW'(1);
          state_nxt = ST_IDLE;
        end
      end
      ST_HDR: begin
        if (emit) begin
          idx_nxt = '0;
          if (held_r == '0) begin
            recs_nxt = recs_r + 32'd1;
            state_nxt = trail_r ? ST_TRAIL : ST_IDLE;
            if (!trail_r) begin
              prev_doc_nxt = newdoc_r;
              prev_lang_nxt = newlang_r;
            end
          end else begin
            state_nxt = ST_RDWAIT;
          end
        end
      end
      ST_RDWAIT: state_nxt = ST_HITS;
      ST_HITS: begin
        if (emit) begin
          if (idx_r + CW'(1) == held_r) begin
            recs_nxt = recs_r + 32'd1;
            state_nxt = trail_r ? ST_TRAIL : ST_IDLE;
            held_nxt = '0;
            prev_hit_nxt = '0;
            if (!trail_r) begin
              prev_doc_nxt = newdoc_r;
              prev_lang_nxt = newlang_r;
            end
          end else begin
            idx_nxt = idx_r + CW'(1);
            state_nxt = ST_RDWAIT;
          end
        end
      end
      ST_TRAIL: begin
        if (emit) begin
          state_nxt = ST_IDLE;
          held_nxt = '0;
          prev_hit_nxt = '0;
          prev_doc_nxt = '0;
          recs_nxt = '0;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // header flush clears hits
    if (state_r == ST_HDR && emit && held_r == '0) begin
      prev_hit_nxt = '0;
    end
  end

  // store port control and outputs
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = newhit_r;
    raddr = '0;
    in_stall = (state_r != ST_IDLE);
    out_valid = 1'b0;
    out_kind = KIND_HEADER;
    out_out_term = '0;
    out_record_count = '0;
    out_out_doc = '0;
    out_out_language = '0;
    out_hit_total = '0;
    out_out_position = '0;
    out_last = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // preload entry below the insertion point
        raddr = IW'(held_r - CW'(1));
      end
      ST_SHIFT: begin
        raddr = IW'(idx_r - CW'(2));
        we = 1'b1;
        if (idx_r != '0 && rdata > newhit_r) begin
          waddr = IW'(idx_r);
          wdata = rdata;
        end else begin
          waddr = IW'(idx_r);
          wdata = newhit_r;
        end
      end
      ST_HDR: begin
        out_valid = 1'b1;
        out_kind = KIND_HEADER;
        out_out_doc = prev_doc_r;
        out_out_language = prev_lang_r;
        out_hit_total = 6'(held_r);
        out_last = (held_r == '0) && !trail_r;
        raddr = '0;
      end
      ST_RDWAIT: raddr = IW'(idx_r);
      ST_HITS: begin
        raddr = IW'(idx_r);
        out_valid = 1'b1;
        out_kind = KIND_HIT;
        out_out_position = rdata;
        out_last = (idx_r + CW'(1) == held_r) && !trail_r;
      end
      ST_TRAIL: begin
        out_valid = 1'b1;
        out_kind = KIND_TRAILER;
        out_out_term = term_r;
        out_record_count = recs_r;
        out_last = 1'b1;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(MAX_HITS)) else $error("hit count over capacity");
  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !out_valid) else $error("result while idle");
  a_trail_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_TRAILER) |-> out_last) else $error("trailer not last");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> in_stall) else $error("accepting while busy");
`endif
endmodule

// ===== rtl/core/pls_store.sv =====
// hit store with one write port and a registered read port; the splicer unit does the sorting
`timescale 1ns / 1ps
module pls_store #(
  parameter int unsigned MAX_HITS = 32,
  parameter int unsigned IW = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic [IW-1:0] raddr,
  output logic [15:0]   rdata
);
  import pls_pkg::*;

  logic [15:0] mem [MAX_HITS];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
